/* hw/rtl/bmrs_pkg.sv */
// ----------------------------------------------------------------------------
// bmrs_pkg
// Shared types and constants of the board-management register slave.
// ----------------------------------------------------------------------------
package bmrs_pkg;

  // field widths
  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 4;
  localparam int REQ_W    = 2;
  localparam int SAMPLE_W = 10;
  localparam int CFG_IX_W = 2;
  localparam int LATCH_W  = 16;
  // average * 129 needs 18 bits
  localparam int PROD_W   = 18;

  // power gain 129 = (1 << 7) + 1
  localparam int POWER_GAIN_SHIFT = 7;

  localparam logic [LATCH_W-1:0] POWER_MAX   = 16'hffff;
  localparam logic [BYTE_W-1:0]  UNUSED_READ = 8'hff;
  localparam logic [BYTE_W-1:0]  TEMP_RESET  = 8'd20;

  localparam logic [BYTE_W-1:0]  BOARD_TYPE_RESET = 8'd3;
  localparam logic [BYTE_W-1:0]  SW_VER_RESET     = 8'd3;
  localparam logic [BYTE_W-1:0]  HW_VER_RESET     = 8'd2;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_BOARD_TYPE = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_SW_VER     = 2'd1;
  localparam logic [CFG_IX_W-1:0] CFG_HW_VER     = 2'd2;

  // bus register map
  localparam logic [IDX_W-1:0] MAP_BOARD_TYPE = 4'd0;
  localparam logic [IDX_W-1:0] MAP_SW_VER     = 4'd1;
  localparam logic [IDX_W-1:0] MAP_HW_VER     = 4'd2;
  localparam logic [IDX_W-1:0] MAP_CONTROL    = 4'd3;
  localparam logic [IDX_W-1:0] MAP_TEMP       = 4'd4;
  localparam logic [IDX_W-1:0] MAP_HEATER     = 4'd5;
  localparam logic [IDX_W-1:0] MAP_QUEUE      = 4'd6;
  localparam logic [IDX_W-1:0] MAP_PWR_LOW    = 4'd7;
  localparam logic [IDX_W-1:0] MAP_PWR_HIGH   = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADDR_MATCH = 3'd0,
    CMD_WRITE_BYTE = 3'd1,
    CMD_READ_BYTE  = 3'd2,
    CMD_POST_REQ   = 3'd3,
    CMD_SAMPLE     = 3'd4,
    CMD_PRELOAD    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_ACC,
    S_FILL,
    S_OUT
  } state_t;

endpackage

/* hw/rtl/bmrs_ram.sv */
// ----------------------------------------------------------------------------
// bmrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/board_mgmt_register_slave_top.sv */
// ----------------------------------------------------------------------------
// board_mgmt_register_slave_top
// Flow: an item is taken in S_IDLE and executed in S_LOOK; a power sample then
//   takes its second pass in S_ACC and a preload sweeps the window in S_FILL
//   (one window RAM write a cycle); S_OUT hands the result to the output register
//   once it is free. in_ready is low while an item is in work or waits in S_OUT.
// Reset: synchronous, active low; afterwards a pass over all 2**WINDOW_SHIFT
//   entries zeroes the sample window, in_ready low; cfg writes are always taken.
// ----------------------------------------------------------------------------
module board_mgmt_register_slave_top #(
  parameter int WINDOW_SHIFT = 7,
  parameter int QUEUE_SLOTS  = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bmrs_pkg::CMD_W-1:0]       in_command,
  input  logic                             in_read_direction,
  input  logic [bmrs_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic [bmrs_pkg::REQ_W-1:0]       in_request_code,
  input  logic [bmrs_pkg::SAMPLE_W-1:0]    in_power_sample,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bmrs_pkg::BYTE_W-1:0]      out_read_data,
  output logic                             out_alert,
  output logic                             out_heater_enable,
  output logic                             out_control_strobe,
  output logic [bmrs_pkg::BYTE_W-1:0]      out_control_value,
  output logic [bmrs_pkg::SAMPLE_W-1:0]    out_power_average,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmrs_pkg::CFG_IX_W-1:0]    cfg_index,
  input  logic [bmrs_pkg::BYTE_W-1:0]      cfg_data
);

  import bmrs_pkg::*;

  localparam int WIN_DEPTH = 1 << WINDOW_SHIFT;
  localparam int TOT_W     = SAMPLE_W + WINDOW_SHIFT;
  localparam int ACC_W     = (TOT_W > PROD_W) ? TOT_W : PROD_W;
  localparam int QAW       = $clog2(QUEUE_SLOTS);
  localparam logic [QAW-1:0] Q_LAST = QAW'(QUEUE_SLOTS - 1);

  // sequencer
  state_t state_r, state_nxt;

  // configuration registers
  logic [BYTE_W-1:0] board_type_r, sw_ver_r, hw_ver_r;

  // register file state
  logic [IDX_W-1:0]    reg_index_r, reg_index_nxt;
  logic                load_pend_r, load_pend_nxt;
  logic [BYTE_W-1:0]   temp_r, temp_nxt;
  logic                heater_r, heater_nxt;
  logic [LATCH_W-1:0]  power_latch_r, power_latch_nxt;
  logic [QAW-1:0]      q_head_r, q_head_nxt;
  logic [QAW-1:0]      q_tail_r, q_tail_nxt;
  logic                alert_r, alert_nxt;
  logic [TOT_W-1:0]    win_total_r, win_total_nxt;
  logic [WINDOW_SHIFT-1:0] win_pos_r, win_pos_nxt;
  logic [WINDOW_SHIFT-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;

  // captured item
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic                rd_dir_r, rd_dir_nxt;
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;

  // staged result fields
  logic [BYTE_W-1:0]   rdata_r, rdata_nxt;
  logic                strobe_r, strobe_nxt;
  logic [BYTE_W-1:0]   cval_r, cval_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_rdata_r, out_rdata_nxt;
  logic                out_alert_r, out_alert_nxt;
  logic                out_heater_r, out_heater_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  logic [BYTE_W-1:0]   out_cval_r, out_cval_nxt;
  logic [SAMPLE_W-1:0] out_avg_r, out_avg_nxt;

  // memories
  logic                    w_we;
  logic [WINDOW_SHIFT-1:0] w_waddr;
  logic [SAMPLE_W-1:0]     w_wdata;
  logic [SAMPLE_W-1:0]     w_rdata;
  logic                    q_we;
  logic [REQ_W-1:0]        q_rdata;

  // shared adder / subtractor
  logic [ACC_W-1:0] alu_a, alu_b, alu_sum;
  logic             alu_sub;

  // helpers
  logic [QAW-1:0]     head_next, tail_next, tail_adv;
  logic [LATCH_W-1:0] power_sat;

  bmrs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WIN_DEPTH)
  ) u_win_ram (
    .clk     (clk),
    .wr_en   (w_we),
    .wr_addr (w_waddr),
    .wr_data (w_wdata),
    .rd_addr (win_pos_r),
    .rd_data (w_rdata)
  );

  bmrs_ram #(
    .WIDTH (REQ_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_req_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_head_r),
    .wr_data (req_r),
    .rd_addr (q_tail_r),
    .rd_data (q_rdata)
  );

  // queue slot stepping, wraps at QUEUE_SLOTS
  assign head_next = (q_head_r == Q_LAST) ? '0 : q_head_r + 1'b1;
  assign tail_next = (q_tail_r == Q_LAST) ? '0 : q_tail_r + 1'b1;

  // shared arithmetic unit
  assign alu_sum   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign power_sat = (alu_sum > ACC_W'(POWER_MAX)) ? POWER_MAX : alu_sum[LATCH_W-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    reg_index_nxt   = reg_index_r;
    load_pend_nxt   = load_pend_r;
    temp_nxt        = temp_r;
    heater_nxt      = heater_r;
    power_latch_nxt = power_latch_r;
    q_head_nxt      = q_head_r;
    q_tail_nxt      = q_tail_r;
    alert_nxt       = alert_r;
    win_total_nxt   = win_total_r;
    win_pos_nxt     = win_pos_r;
    fill_cnt_nxt    = fill_cnt_r;
    avg_nxt         = avg_r;
    cmd_nxt         = cmd_r;
    rd_dir_nxt      = rd_dir_r;
    data_nxt        = data_r;
    req_nxt         = req_r;
    sample_nxt      = sample_r;
    rdata_nxt       = rdata_r;
    strobe_nxt      = strobe_r;
    cval_nxt        = cval_r;
    out_rdata_nxt   = out_rdata_r;
    out_alert_nxt   = out_alert_r;
    out_heater_nxt  = out_heater_r;
    out_strobe_nxt  = out_strobe_r;
    out_cval_nxt    = out_cval_r;
    out_avg_nxt     = out_avg_r;
    w_we            = 1'b0;
    w_waddr         = win_pos_r;
    w_wdata         = sample_r;
    q_we            = 1'b0;
    alu_a           = ACC_W'(win_total_r);
    alu_b           = ACC_W'(sample_r);
    alu_sub         = 1'b0;
    tail_adv        = q_tail_r;

    // result taken downstream
    out_valid_nxt = out_valid_r & ~out_ready;

    case (state_r)
      // zero the sample window after reset
      S_CLEAR: begin
        w_we         = 1'b1;
        w_waddr      = fill_cnt_r;
        w_wdata      = '0;
        fill_cnt_nxt = fill_cnt_r + 1'b1;
        if (fill_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      // capture the item; RAM reads at tail and window position are issued
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          rd_dir_nxt = in_read_direction;
          data_nxt   = in_data_byte;
          req_nxt    = in_request_code;
          sample_nxt = in_power_sample;
          state_nxt  = S_LOOK;
        end
      end

      // execute the item with RAM read data in hand
      S_LOOK: begin
        rdata_nxt  = '0;
        strobe_nxt = 1'b0;
        cval_nxt   = '0;
        state_nxt  = S_OUT;
        case (cmd_t'(cmd_r))
          CMD_ADDR_MATCH: begin
            if (!rd_dir_r) begin
              load_pend_nxt = 1'b1;
            end
          end

          CMD_WRITE_BYTE: begin
            if (load_pend_r) begin
              reg_index_nxt = data_r[IDX_W-1:0];
              load_pend_nxt = 1'b0;
            end else begin
              case (reg_index_r)
                MAP_CONTROL: begin
                  strobe_nxt = 1'b1;
                  cval_nxt   = data_r;
                end
                MAP_TEMP:   temp_nxt   = data_r;
                MAP_HEATER: heater_nxt = |data_r;
                MAP_QUEUE: begin
                  // acknowledge: drop the oldest request at the tail, clear alert once empty
                  if (q_head_r != q_tail_r) begin
                    tail_adv = tail_next;
                  end
                  q_tail_nxt = tail_adv;
                  if (q_head_r == tail_adv) begin
                    alert_nxt = 1'b0;
                  end
                end
                default: ;
              endcase
              reg_index_nxt = reg_index_r + 1'b1;
            end
          end

          CMD_READ_BYTE: begin
            case (reg_index_r)
              MAP_BOARD_TYPE: rdata_nxt = board_type_r;
              MAP_SW_VER:     rdata_nxt = sw_ver_r;
              MAP_HW_VER:     rdata_nxt = hw_ver_r;
              MAP_CONTROL:    rdata_nxt = '0;
              MAP_TEMP:       rdata_nxt = temp_r;
              MAP_HEATER:     rdata_nxt = BYTE_W'(heater_r);
              MAP_QUEUE: begin
                rdata_nxt = (q_head_r == q_tail_r) ? '0 : BYTE_W'(q_rdata);
              end
              MAP_PWR_LOW: begin
                // average * 129 through the shared adder, saturated
                alu_a           = ACC_W'(avg_r) << POWER_GAIN_SHIFT;
                alu_b           = ACC_W'(avg_r);
                power_latch_nxt = power_sat;
                rdata_nxt       = power_sat[BYTE_W-1:0];
              end
              MAP_PWR_HIGH:   rdata_nxt = power_latch_r[LATCH_W-1:BYTE_W];
              default:        rdata_nxt = UNUSED_READ;
            endcase
            reg_index_nxt = reg_index_r + 1'b1;
          end

          CMD_POST_REQ: begin
            if (head_next != q_tail_r) begin
              q_we       = 1'b1;
              q_head_nxt = head_next;
            end
            alert_nxt = 1'b1;
          end

          CMD_SAMPLE: begin
            // first pass: remove the oldest sample from the total
            alu_a         = ACC_W'(win_total_r);
            alu_b         = ACC_W'(w_rdata);
            alu_sub       = 1'b1;
            win_total_nxt = alu_sum[TOT_W-1:0];
            state_nxt     = S_ACC;
          end

          CMD_PRELOAD: begin
            win_total_nxt = TOT_W'(sample_r) << WINDOW_SHIFT;
            avg_nxt       = sample_r;
            win_pos_nxt   = '0;
            fill_cnt_nxt  = '0;
            state_nxt     = S_FILL;
          end

          default: ;
        endcase
      end

      // second pass: add the new sample, store it, update the average
      S_ACC: begin
        win_total_nxt = alu_sum[TOT_W-1:0];
        avg_nxt       = alu_sum[WINDOW_SHIFT +: SAMPLE_W];
        w_we          = 1'b1;
        win_pos_nxt   = win_pos_r + 1'b1;
        state_nxt     = S_OUT;
      end

      // preload sweep, one window entry a cycle
      S_FILL: begin
        w_we         = 1'b1;
        w_waddr      = fill_cnt_r;
        fill_cnt_nxt = fill_cnt_r + 1'b1;
        if (fill_cnt_r == '1) begin
          state_nxt = S_OUT;
        end
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_rdata_nxt  = rdata_r;
          out_alert_nxt  = alert_r;
          out_heater_nxt = heater_r;
          out_strobe_nxt = strobe_r;
          out_cval_nxt   = cval_r;
          out_avg_nxt    = avg_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      fill_cnt_r    <= '0;
      reg_index_r   <= '0;
      load_pend_r   <= 1'b0;
      temp_r        <= TEMP_RESET;
      heater_r      <= 1'b0;
      power_latch_r <= '0;
      q_head_r      <= '0;
      q_tail_r      <= '0;
      alert_r       <= 1'b0;
      win_total_r   <= '0;
      win_pos_r     <= '0;
      avg_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fill_cnt_r    <= fill_cnt_nxt;
      reg_index_r   <= reg_index_nxt;
      load_pend_r   <= load_pend_nxt;
      temp_r        <= temp_nxt;
      heater_r      <= heater_nxt;
      power_latch_r <= power_latch_nxt;
      q_head_r      <= q_head_nxt;
      q_tail_r      <= q_tail_nxt;
      alert_r       <= alert_nxt;
      win_total_r   <= win_total_nxt;
      win_pos_r     <= win_pos_nxt;
      avg_r         <= avg_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_type_r <= BOARD_TYPE_RESET;
      sw_ver_r     <= SW_VER_RESET;
      hw_ver_r     <= HW_VER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOARD_TYPE: board_type_r <= cfg_data;
        CFG_SW_VER:     sw_ver_r     <= cfg_data;
        CFG_HW_VER:     hw_ver_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    rd_dir_r     <= rd_dir_nxt;
    data_r       <= data_nxt;
    req_r        <= req_nxt;
    sample_r     <= sample_nxt;
    rdata_r      <= rdata_nxt;
    strobe_r     <= strobe_nxt;
    cval_r       <= cval_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_alert_r  <= out_alert_nxt;
    out_heater_r <= out_heater_nxt;
    out_strobe_r <= out_strobe_nxt;
    out_cval_r   <= out_cval_nxt;
    out_avg_r    <= out_avg_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_rdata_r;
  assign out_alert          = out_alert_r;
  assign out_heater_enable  = out_heater_r;
  assign out_control_strobe = out_strobe_r;
  assign out_control_value  = out_cval_r;
  assign out_power_average  = out_avg_r;

endmodule
